// ===== design/uv_sphere_mesh_generator_core_defines.svh =====
// Assertion macros for the UV sphere mesh generator.
// Used by the top level only; no other dependencies.
`ifndef UV_SPHERE_MESH_GENERATOR_CORE_DEFINES_SVH
`define UV_SPHERE_MESH_GENERATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define UVS_ASSERT_IMP(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("uvs assertion failed");
`define UVS_ASSERT_NXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("uvs assertion failed");
`else
`define UVS_ASSERT_IMP(lbl, ck, rs, ante, cons)
`define UVS_ASSERT_NXT(lbl, ck, rs, ante, cons)
`endif
`endif

// ===== design/uvs_pkg.sv =====
// Shared types, constants, sine table and lookup for the UV sphere generator.
// No dependencies.
package uvs_pkg;

  localparam int SINE_DEPTH = 256;
  localparam int IDX_W      = $clog2(SINE_DEPTH + 1);
  localparam int COORD_W    = 32;
  localparam logic [7:0] MIN_SECTORS = 8'd3;
  localparam logic [7:0] MIN_STACKS  = 8'd2;
  localparam logic [15:0] QUARTER_TURN = 16'd16384;

  typedef enum logic [1:0] {
    KIND_VERTEX   = 2'd0,
    KIND_TRIANGLE = 2'd1,
    KIND_DONE     = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    CFG_CENTER_X  = 3'd0,
    CFG_CENTER_Y  = 3'd1,
    CFG_CENTER_Z  = 3'd2,
    CFG_RADIUS    = 3'd3,
    CFG_SECTORS   = 3'd4,
    CFG_STACKS    = 3'd5,
    CFG_SEC_STEP  = 3'd6,
    CFG_STK_STEP  = 3'd7
  } cfg_reg_t;

  typedef enum logic [2:0] {
    MUL_NONE,
    MUL_RING_COS,
    MUL_RING_SIN,
    MUL_VERT_X,
    MUL_VERT_Z
  } mul_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_RING_COS,
    ST_RING_SIN,
    ST_VERT_X,
    ST_VERT_Z,
    ST_EMIT_VERT,
    ST_ADV_VERT,
    ST_TRI_LATCH,
    ST_ADV_TRI,
    ST_EMIT_TRI,
    ST_EMIT_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic    take;
    logic    adv_init;
    logic    adv_skip;
    logic    adv_step;
    logic    vert_adv;
    logic    tri_latch;
    mul_op_t mul_op;
    logic    load_en;
    kind_t   load_kind;
  } ctrl_cmd_t;

  typedef struct packed {
    kind_t phase;
    logic  col_zero;
    logic  to_tri;
    logic  adv_stop;
    logic  out_busy;
  } dp_stat_t;

  typedef struct packed {
    logic        neg;
    logic [16:0] mag;
  } sine_t;

  typedef logic [16:0] sine_rom_t [0:SINE_DEPTH];
  typedef longint unsigned taylor_div_t [0:6];

  localparam taylor_div_t TAYLOR_DIV = '{64'd1, 64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156};

  // Q30 Taylor series through x^13, rounded to Q16; evaluated at elaboration.
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    longint unsigned x, x2, term;
    longint sum, v;
    for (int i = 0; i <= SINE_DEPTH; i++) begin
      x = (64'd1686629713 * longint'(i)) / SINE_DEPTH;
      x2 = (x * x) >> 30;
      term = x;
      sum = longint'(x);
      for (int k = 1; k <= 6; k++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[k];
        if (k % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) sum = 0;
      v = (sum + 8192) / 16384;
      if (v > 65536) v = 65536;
      rom[i] = 17'(v);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // Quarter-wave lookup: quadrants 1 and 3 mirror, quadrants 2 and 3 negate.
  function automatic sine_t sine_lookup(input logic [15:0] p);
    sine_t res;
    logic [31:0] scaled;
    logic [IDX_W-1:0] idx;
    scaled = 32'(p[13:0]) * 32'(SINE_DEPTH);
    idx = scaled[14 +: IDX_W];
    if (p[14]) begin
      idx = IDX_W'(SINE_DEPTH) - idx;
    end
    res.mag = SINE_ROM[idx];
    res.neg = p[15];
    return res;
  endfunction

endpackage

// ===== design/uvs_datapath.sv =====
// Datapath: config registers, mesh counters, shared multiplier, output register.
// Depends on uvs_pkg.
module uvs_datapath import uvs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              restart,
  input  ctrl_cmd_t         cmd,
  output dp_stat_t          stat,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [1:0]        element_kind,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic [15:0]       corner_a,
  output logic [15:0]       corner_b,
  output logic [15:0]       corner_c,
  output logic              last_of_mesh
);

  logic signed [31:0] center_x, center_y, center_z;
  logic [30:0] sphere_radius;
  logic [7:0]  sector_count, stack_count;
  logic [15:0] sector_step, stack_step;

  kind_t       phase;
  logic [7:0]  row, col;
  logic        second_tri;
  logic [15:0] row_base, stack_angle, sector_angle;
  logic signed [31:0] ring_radius, ring_height, prod_x, prod_z;
  logic [1:0]  adv_n;
  logic        adv_skip;
  logic        tri_last;
  logic [15:0] tri_a, tri_b, tri_c;

  logic [7:0] c_eff, s_eff;
  assign c_eff = (sector_count < MIN_SECTORS) ? MIN_SECTORS : sector_count;
  assign s_eff = (stack_count < MIN_STACKS) ? MIN_STACKS : stack_count;

  // shared multiplier, sign-magnitude with rounding half away from zero
  logic        a_neg;
  logic [30:0] a_mag;
  logic [15:0] ph;
  sine_t       sv;
  logic [47:0] prod;
  logic [47:0] rounded;
  logic signed [31:0] mul_res;

  always_comb begin
    a_neg = 1'b0;
    a_mag = sphere_radius;
    ph    = stack_angle;
    case (cmd.mul_op)
      MUL_RING_COS: ph = stack_angle + QUARTER_TURN;
      MUL_RING_SIN: ph = stack_angle;
      MUL_VERT_X, MUL_VERT_Z: begin
        a_neg = ring_radius[31];
        a_mag = ring_radius[31] ? 31'(-ring_radius) : ring_radius[30:0];
        ph    = (cmd.mul_op == MUL_VERT_Z) ? sector_angle + QUARTER_TURN : sector_angle;
      end
      default: ph = stack_angle;
    endcase
    sv      = sine_lookup(ph);
    prod    = 48'(a_mag) * 48'(sv.mag);
    rounded = prod + 48'd32768;
    mul_res = (a_neg ^ sv.neg) ? -$signed({1'b0, rounded[46:16]})
                               : $signed({1'b0, rounded[46:16]});
  end

  function automatic logic [31:0] sat_add(input logic signed [31:0] a,
                                          input logic signed [31:0] b);
    logic signed [32:0] s;
    s = 33'(a) + 33'(b);
    if (s[32] != s[31]) begin
      return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return s[31:0];
  endfunction

  // triangle slot advance, one iteration per cycle
  logic        mv_en, mv_end, valid_next;
  logic [7:0]  row_n, col_n;
  logic        st2_n;
  logic [15:0] base_n;

  always_comb begin
    mv_en  = adv_skip || (adv_n != 2'd0);
    mv_end = 1'b0;
    row_n  = row;
    col_n  = col;
    st2_n  = second_tri;
    base_n = row_base;
    if (mv_en) begin
      if (!second_tri) begin
        st2_n = 1'b1;
      end else begin
        st2_n = 1'b0;
        if (col >= c_eff - 8'd1) begin
          col_n = '0;
          if (row >= s_eff - 8'd1) begin
            mv_end = 1'b1;
          end else begin
            row_n  = row + 8'd1;
            base_n = row_base + 16'(c_eff) + 16'd1;
          end
        end else begin
          col_n = col + 8'd1;
        end
      end
    end
    valid_next = st2_n ? (row_n < s_eff - 8'd1) : (row_n != 8'd0);
  end

  logic adv_end;
  assign adv_end = mv_end || !valid_next;

  assign stat.phase    = phase;
  assign stat.col_zero = (col == 8'd0);
  assign stat.to_tri   = (col >= c_eff) && (row >= s_eff);
  assign stat.adv_stop = mv_end || valid_next || (adv_n == 2'd3);
  assign stat.out_busy = result_valid && result_stall;

  logic [15:0] k1, k2;
  assign k1 = row_base + 16'(col);
  assign k2 = k1 + 16'(c_eff) + 16'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x      <= '0;
      center_y      <= '0;
      center_z      <= '0;
      sphere_radius <= 31'd65536;
      sector_count  <= 8'd36;
      stack_count   <= 8'd18;
      sector_step   <= 16'd1820;
      stack_step    <= 16'd1820;
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        CFG_CENTER_X: center_x      <= cfg_data;
        CFG_CENTER_Y: center_y      <= cfg_data;
        CFG_CENTER_Z: center_z      <= cfg_data;
        CFG_RADIUS:   sphere_radius <= cfg_data[30:0];
        CFG_SECTORS:  sector_count  <= cfg_data[7:0];
        CFG_STACKS:   stack_count   <= cfg_data[7:0];
        CFG_SEC_STEP: sector_step   <= cfg_data[15:0];
        CFG_STK_STEP: stack_step    <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= KIND_DONE;
      row          <= '0;
      col          <= '0;
      second_tri   <= 1'b0;
      row_base     <= '0;
      stack_angle  <= QUARTER_TURN;
      sector_angle <= '0;
      ring_radius  <= '0;
      ring_height  <= '0;
      adv_n        <= '0;
      adv_skip     <= 1'b0;
      tri_last     <= 1'b0;
    end else begin
      if (cmd.take && restart) begin
        phase        <= KIND_VERTEX;
        row          <= '0;
        col          <= '0;
        second_tri   <= 1'b0;
        row_base     <= '0;
        stack_angle  <= QUARTER_TURN;
        sector_angle <= '0;
      end
      case (cmd.mul_op)
        MUL_RING_COS: ring_radius <= mul_res;
        MUL_RING_SIN: ring_height <= mul_res;
        default: ;
      endcase
      if (cmd.vert_adv) begin
        if (col >= c_eff) begin
          col          <= '0;
          sector_angle <= '0;
          stack_angle  <= stack_angle - stack_step;
          if (row >= s_eff) begin
            phase      <= KIND_TRIANGLE;
            row        <= '0;
            second_tri <= 1'b0;
            row_base   <= '0;
          end else begin
            row <= row + 8'd1;
          end
        end else begin
          col          <= col + 8'd1;
          sector_angle <= sector_angle + sector_step;
        end
      end
      if (cmd.adv_init) begin
        adv_n    <= '0;
        adv_skip <= cmd.adv_skip;
      end
      if (cmd.tri_latch) begin
        tri_last <= 1'b0;
      end
      if (cmd.adv_step) begin
        row        <= row_n;
        col        <= col_n;
        second_tri <= st2_n;
        row_base   <= base_n;
        adv_n      <= adv_n + 2'd1;
        if (stat.adv_stop && adv_end) begin
          phase    <= KIND_DONE;
          tri_last <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.mul_op)
      MUL_VERT_X: prod_x <= mul_res;
      MUL_VERT_Z: prod_z <= mul_res;
      default: ;
    endcase
    if (cmd.tri_latch) begin
      tri_a <= second_tri ? k1 + 16'd1 : k1;
      tri_b <= k2;
      tri_c <= second_tri ? k2 + 16'd1 : k1 + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.load_en) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_en) begin
      element_kind <= cmd.load_kind;
      case (cmd.load_kind)
        KIND_VERTEX: begin
          pos_x        <= sat_add(center_x, prod_x);
          pos_y        <= sat_add(center_y, ring_height);
          pos_z        <= sat_add(center_z, prod_z);
          corner_a     <= '0;
          corner_b     <= '0;
          corner_c     <= '0;
          last_of_mesh <= 1'b0;
        end
        KIND_TRIANGLE: begin
          pos_x        <= '0;
          pos_y        <= '0;
          pos_z        <= '0;
          corner_a     <= tri_a;
          corner_b     <= tri_b;
          corner_c     <= tri_c;
          last_of_mesh <= tri_last;
        end
        default: begin
          pos_x        <= '0;
          pos_y        <= '0;
          pos_z        <= '0;
          corner_a     <= '0;
          corner_b     <= '0;
          corner_c     <= '0;
          last_of_mesh <= 1'b0;
        end
      endcase
    end
  end

endmodule

// ===== design/uvs_controller.sv =====
// Controller state machine sequencing vertex math, slot advance and output loads.
// Depends on uvs_pkg.
module uvs_controller import uvs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  dp_stat_t   stat,
  output ctrl_cmd_t  cmd
);

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (item_valid) state_next = ST_DISPATCH;
      ST_DISPATCH: begin
        case (stat.phase)
          KIND_VERTEX:   state_next = stat.col_zero ? ST_RING_COS : ST_VERT_X;
          KIND_TRIANGLE: state_next = ST_TRI_LATCH;
          default:       state_next = ST_EMIT_DONE;
        endcase
      end
      ST_RING_COS:  state_next = ST_RING_SIN;
      ST_RING_SIN:  state_next = ST_VERT_X;
      ST_VERT_X:    state_next = ST_VERT_Z;
      ST_VERT_Z:    state_next = ST_EMIT_VERT;
      ST_EMIT_VERT: if (!stat.out_busy) state_next = stat.to_tri ? ST_ADV_VERT : ST_IDLE;
      ST_ADV_VERT:  if (stat.adv_stop) state_next = ST_IDLE;
      ST_TRI_LATCH: state_next = ST_ADV_TRI;
      ST_ADV_TRI:   if (stat.adv_stop) state_next = ST_EMIT_TRI;
      ST_EMIT_TRI:  if (!stat.out_busy) state_next = ST_IDLE;
      ST_EMIT_DONE: if (!stat.out_busy) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    cmd.mul_op    = MUL_NONE;
    cmd.load_kind = KIND_DONE;
    item_stall    = (state != ST_IDLE);
    case (state)
      ST_IDLE:     cmd.take = item_valid;
      ST_RING_COS: cmd.mul_op = MUL_RING_COS;
      ST_RING_SIN: cmd.mul_op = MUL_RING_SIN;
      ST_VERT_X:   cmd.mul_op = MUL_VERT_X;
      ST_VERT_Z:   cmd.mul_op = MUL_VERT_Z;
      ST_EMIT_VERT: begin
        if (!stat.out_busy) begin
          cmd.load_en   = 1'b1;
          cmd.load_kind = KIND_VERTEX;
          cmd.vert_adv  = 1'b1;
          cmd.adv_init  = 1'b1;
        end
      end
      ST_ADV_VERT, ST_ADV_TRI: cmd.adv_step = 1'b1;
      ST_TRI_LATCH: begin
        cmd.tri_latch = 1'b1;
        cmd.adv_init  = 1'b1;
        cmd.adv_skip  = 1'b1;
      end
      ST_EMIT_TRI: begin
        cmd.load_en   = !stat.out_busy;
        cmd.load_kind = KIND_TRIANGLE;
      end
      ST_EMIT_DONE: begin
        cmd.load_en   = !stat.out_busy;
        cmd.load_kind = KIND_DONE;
      end
      default: ;
    endcase
  end

endmodule

// ===== design/uv_sphere_mesh_generator_core.sv =====
// Top level of the UV sphere mesh generator: controller plus datapath.
// Depends on uvs_pkg, uvs_controller, uvs_datapath and the defines header.
//
//   channel   handshake                 payload
//   item      item_valid / item_stall   restart
//   result    result_valid/result_stall element_kind pos_x/y/z corner_a/b/c last_of_mesh
//   cfg       cfg_valid / cfg_ready     cfg_index cfg_data
//
// A vertex at column 0 runs two ring multiplies and two vertex multiplies on one
// shared multiplier; other vertices run only the vertex multiplies; triangles run a
// slot advance (up to four slots, one slot per cycle). The last vertex runs it too.
// Synchronous active-high reset; no clearing pass. A stalled result holds the
// emit state until transferred; the next item is taken while a result waits.
`include "uv_sphere_mesh_generator_core_defines.svh"
module uv_sphere_mesh_generator_core import uvs_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic              restart,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [1:0]        element_kind,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic [15:0]       corner_a,
  output logic [15:0]       corner_b,
  output logic [15:0]       corner_c,
  output logic              last_of_mesh
);

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  logic      pos_zero, corners_zero;

  assign cfg_ready = 1'b1;
  assign pos_zero     = (pos_x == '0) && (pos_y == '0) && (pos_z == '0);
  assign corners_zero = (corner_a == '0) && (corner_b == '0) && (corner_c == '0);

  uvs_controller u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  uvs_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .restart      (restart),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .element_kind (element_kind),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .corner_a     (corner_a),
    .corner_b     (corner_b),
    .corner_c     (corner_c),
    .last_of_mesh (last_of_mesh)
  );

  `UVS_ASSERT_NXT(a_busy_after_take, clk, rst, item_valid && !item_stall, item_stall)
  `UVS_ASSERT_IMP(a_last_is_tri, clk, rst, result_valid && last_of_mesh, element_kind == KIND_TRIANGLE)
  `UVS_ASSERT_IMP(a_pos_zero, clk, rst, result_valid && element_kind != KIND_VERTEX, pos_zero)
  `UVS_ASSERT_IMP(a_corner_zero, clk, rst, result_valid && element_kind != KIND_TRIANGLE, corners_zero)

endmodule

// ===== sim/uv_sphere_mesh_generator_core_checker.sv =====
// Mesh checker: watches the config, item and result channels of the UV sphere
// generator, predicts each element from its own copy of the state and compares.
// Depends on uvs_pkg for the element kinds, register indexes and constants.
module uv_sphere_mesh_generator_core_checker import uvs_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        item_valid,
  input  logic        item_stall,
  input  logic        restart,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic [1:0]  element_kind,
  input  logic [31:0] pos_x,
  input  logic [31:0] pos_y,
  input  logic [31:0] pos_z,
  input  logic [15:0] corner_a,
  input  logic [15:0] corner_b,
  input  logic [15:0] corner_c,
  input  logic        last_of_mesh,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    kind_t       kind;
    logic [31:0] x, y, z;
    logic [15:0] a, b, c;
    logic        last;
  } element_t;

  element_t expected_elems[$];
  longint   quarter_sine[0:256];

  logic signed [31:0] ctr_x, ctr_y, ctr_z;
  logic [30:0] radius;
  logic [7:0]  sectors, stacks;
  logic [15:0] sec_step, stk_step;

  kind_t       phase;
  logic [7:0]  row, col;
  logic        upper_tri;
  logic [15:0] base_idx, stk_ang, sec_ang;
  longint      ring_r, ring_h;

  initial begin
    longint unsigned x, x2, term;
    longint sum, v;
    int div;
    for (int i = 0; i <= 256; i++) begin
      x = (64'd1686629713 * i) / 256;
      x2 = (x * x) >> 30;
      term = x;
      sum = x;
      for (int k = 1; k <= 6; k++) begin
        div = (2 * k) * (2 * k + 1);
        term = ((term * x2) >> 30) / div;
        if (k % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      if (sum < 0) sum = 0;
      v = (sum + 8192) / 16384;
      if (v > 65536) v = 65536;
      quarter_sine[i] = v;
    end
  end

  function automatic longint sin_q16(logic [15:0] p);
    int idx;
    longint mag;
    idx = (int'(p[13:0]) * 256) >> 14;
    mag = p[14] ? quarter_sine[256 - idx] : quarter_sine[idx];
    return p[15] ? -mag : mag;
  endfunction

  function automatic longint cos_q16(logic [15:0] p);
    return sin_q16(p + 16'd16384);
  endfunction

  // round half away from zero
  function automatic longint scale_q16(longint a, longint s);
    longint m;
    m = ((a < 0 ? -a : a) * (s < 0 ? -s : s) + 32768) >>> 16;
    return ((a < 0) != (s < 0)) ? -m : m;
  endfunction

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  function automatic bit slot_live(int s);
    return upper_tri ? (row < s - 1) : (row != 0);
  endfunction

  // moves past unused triangle slots; returns 1 at the end of the mesh
  function automatic bit next_slot(int c, int s, bit skip);
    for (int n = 0; n < 4; n++) begin
      if (skip || n > 0) begin
        if (!upper_tri) begin
          upper_tri = 1'b1;
        end else begin
          upper_tri = 1'b0;
          if (col >= c - 1) begin
            col = '0;
            if (row >= s - 1) return 1'b1;
            row = row + 8'd1;
            base_idx = base_idx + 16'(c + 1);
          end else begin
            col = col + 8'd1;
          end
        end
      end
      if (slot_live(s)) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic element_t mesh_step(logic rs);
    element_t e;
    int c, s;
    logic [15:0] k1, k2;
    c = sectors < MIN_SECTORS ? 3 : sectors;
    s = stacks < MIN_STACKS ? 2 : stacks;
    e = '{KIND_DONE, 0, 0, 0, 0, 0, 0, 0};
    if (rs) begin
      phase = KIND_VERTEX; row = 0; col = 0; upper_tri = 0;
      base_idx = 0; stk_ang = QUARTER_TURN; sec_ang = 0;
    end
    if (phase == KIND_VERTEX) begin
      if (col == 0) begin
        ring_r = scale_q16(radius, cos_q16(stk_ang));
        ring_h = scale_q16(radius, sin_q16(stk_ang));
      end
      e.kind = KIND_VERTEX;
      e.x = clamp32(longint'(ctr_x) + scale_q16(ring_r, sin_q16(sec_ang)));
      e.y = clamp32(longint'(ctr_y) + ring_h);
      e.z = clamp32(longint'(ctr_z) + scale_q16(ring_r, cos_q16(sec_ang)));
      if (col >= c) begin
        col = 0;
        sec_ang = 0;
        stk_ang = stk_ang - stk_step;
        if (row >= s) begin
          phase = KIND_TRIANGLE;
          row = 0; col = 0; upper_tri = 0; base_idx = 0;
          if (next_slot(c, s, 1'b0)) phase = KIND_DONE;
        end else begin
          row = row + 8'd1;
        end
      end else begin
        col = col + 8'd1;
        sec_ang = sec_ang + sec_step;
      end
    end else if (phase == KIND_TRIANGLE) begin
      k1 = base_idx + 16'(col);
      k2 = k1 + 16'(c + 1);
      e.kind = KIND_TRIANGLE;
      if (!upper_tri) begin
        e.a = k1; e.b = k2; e.c = k1 + 16'd1;
      end else begin
        e.a = k1 + 16'd1; e.b = k2; e.c = k2 + 16'd1;
      end
      if (next_slot(c, s, 1'b1)) begin
        phase = KIND_DONE;
        e.last = 1'b1;
      end
    end
    return e;
  endfunction

  task automatic report(string what, longint got, longint want);
    $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    element_t w;
    if (rst) begin
      expected_elems.delete();
      ctr_x <= 0; ctr_y <= 0; ctr_z <= 0; radius <= 31'd65536;
      sectors <= 8'd36; stacks <= 8'd18; sec_step <= 16'd1820; stk_step <= 16'd1820;
      phase <= KIND_DONE; row <= 0; col <= 0; upper_tri <= 0; base_idx <= 0;
      stk_ang <= QUARTER_TURN; sec_ang <= 0; ring_r <= 0; ring_h <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          CFG_CENTER_X: ctr_x = cfg_data;
          CFG_CENTER_Y: ctr_y = cfg_data;
          CFG_CENTER_Z: ctr_z = cfg_data;
          CFG_RADIUS:   radius = cfg_data[30:0];
          CFG_SECTORS:  sectors = cfg_data[7:0];
          CFG_STACKS:   stacks = cfg_data[7:0];
          CFG_SEC_STEP: sec_step = cfg_data[15:0];
          CFG_STK_STEP: stk_step = cfg_data[15:0];
          default: ;
        endcase
      end
      if (result_valid && !result_stall) begin
        if (expected_elems.size() == 0) begin
          $display("%0t unexpected result transfer", $realtime);
          errors++;
        end else begin
          w = expected_elems.pop_front();
          if (element_kind != w.kind) report("kind", element_kind, w.kind);
          if (pos_x != w.x) report("pos_x", pos_x, w.x);
          if (pos_y != w.y) report("pos_y", pos_y, w.y);
          if (pos_z != w.z) report("pos_z", pos_z, w.z);
          if (corner_a != w.a) report("corner_a", corner_a, w.a);
          if (corner_b != w.b) report("corner_b", corner_b, w.b);
          if (corner_c != w.c) report("corner_c", corner_c, w.c);
          if (last_of_mesh != w.last) report("last_of_mesh", last_of_mesh, w.last);
        end
      end
      if (item_valid && !item_stall) expected_elems = {expected_elems, mesh_step(restart)};
    end
    pending <= expected_elems.size();
  end

  initial errors = 0;
endmodule

// ===== sim/uv_sphere_mesh_generator_core_test.sv =====
// Testbench top for the UV sphere mesh generator: clock, reset, register
// writes, element requests with random gaps and stalls, watchdog and verdict.
// Depends on uvs_pkg, the core and uv_sphere_mesh_generator_core_checker.
module uv_sphere_mesh_generator_core_test;
  import uvs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0, rst = 1;
  logic cfg_valid = 0, cfg_ready;
  logic [2:0] cfg_index = 0;
  logic [31:0] cfg_data = 0;
  logic item_valid = 0, item_stall, restart = 0;
  logic result_valid, result_stall = 1;
  logic [1:0] element_kind;
  logic signed [31:0] pos_x, pos_y, pos_z;
  logic [15:0] corner_a, corner_b, corner_c;
  logic last_of_mesh;
  int errors, pending, items_sent, idle_cycles, stall_left;
  bit calm;

  always #4 clk = ~clk;

  uv_sphere_mesh_generator_core DUT (.*);
  uv_sphere_mesh_generator_core_checker mesh_checker (.*);

  // result-side stall, redrawn after each result transfer
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
      result_stall <= 1'b0;
    end else if (result_valid && !result_stall) begin
      stall_left <= calm ? 0 : $urandom_range(0, 4);
      result_stall <= calm ? 1'b0 : ($urandom_range(0, 1) == 1);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      result_stall <= 1'b1;
    end else begin
      result_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst || (cfg_valid && cfg_ready) || (item_valid && !item_stall) ||
        (result_valid && !result_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == 5000) begin
        $display("uv_sphere_mesh_generator_core_test NOT OK");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic request(logic rs);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    restart <= rs;
    do @(posedge clk); while (item_stall);
    items_sent++;
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  function automatic logic [31:0] pick32();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF;
      3: return 0;
      default: return $urandom;
    endcase
  endfunction

  task automatic set_all(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz, logic [31:0] r,
                         logic [7:0] ns, logic [7:0] nt, logic [15:0] ss, logic [15:0] ts);
    write_reg(CFG_CENTER_X, cx);
    write_reg(CFG_CENTER_Y, cy);
    write_reg(CFG_CENTER_Z, cz);
    write_reg(CFG_RADIUS, r);
    write_reg(CFG_SECTORS, ns);
    write_reg(CFG_STACKS, nt);
    write_reg(CFG_SEC_STEP, ss);
    write_reg(CFG_STK_STEP, ts);
  endtask

  initial begin
    int n, mesh_len;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: finished state at reset, then short meshes at the extremes
    request(1'b0);
    request(1'b0);
    request(1'b1);
    repeat (3) request(1'b0);
    drain();
    set_all(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 8'd0, 8'd0,
            16'hFFFF, 16'd32768);
    request(1'b1);
    repeat (7) request(1'b0);
    drain();
    // smallest mesh through its first triangle, counts below minimum saturate
    set_all(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 0, 8'd1, 8'd1, 0, 0);
    request(1'b1);
    repeat (12) request(1'b0);
    drain();
    set_all(0, 0, 0, 32'h0001_0000, 8'd255, 8'd255, 16'd257, 16'd129);
    request(1'b1);
    repeat (3) request(1'b0);
    drain();

    while (items_sent < 1700) begin
      calm = ($urandom_range(0, 5) == 0);
      // registers rewritten mid-mesh too: the counters may end up past the new counts
      for (int i = 0; i < 8; i++) begin
        if ($urandom_range(0, 2) != 0) begin
          case (cfg_reg_t'(i))
            CFG_SECTORS: write_reg(CFG_SECTORS, ($urandom_range(0, 9) == 0) ?
                                   $urandom : $urandom_range(0, 6));
            CFG_STACKS:  write_reg(CFG_STACKS, ($urandom_range(0, 9) == 0) ?
                                   $urandom : $urandom_range(0, 5));
            CFG_STK_STEP: write_reg(CFG_STK_STEP, ($urandom_range(0, 3) == 0) ?
                                    $urandom : $urandom_range(0, 32768));
            default: write_reg(cfg_reg_t'(i), pick32());
          endcase
        end
      end
      mesh_len = $urandom_range(10, 90);
      n = 0;
      if ($urandom_range(0, 3) != 0) request(1'b1);
      while (n < mesh_len) begin
        request($urandom_range(0, 40) == 0);
        n++;
        if (n == 20 && items_sent > 800 && items_sent < 900) begin
          // hold off until every result is back
          item_valid <= 1'b0;
          @(posedge clk);
          while (pending != 0) @(posedge clk);
        end
      end
      drain();
    end
    calm = 0;
    drain();
    if (errors == 0 && pending == 0) begin
      $display("uv_sphere_mesh_generator_core_test OK");
    end else begin
      $display("uv_sphere_mesh_generator_core_test NOT OK");
    end
    $finish;
  end
endmodule
